// File: rtl/vclw_pkg.sv
package vclw_pkg;

    localparam int unsigned TimeW   = 48;
    localparam int unsigned VelW    = 16;
    localparam int unsigned LimW    = 15;
    localparam int unsigned TmoW    = 26;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 26;
    localparam int unsigned QBits   = 15;
    localparam int unsigned BitIdxW = 4;
    localparam int unsigned MulW    = 32;
    localparam int unsigned ProdW   = 64;
    localparam int unsigned CmpW    = 62;

    localparam logic [CfgIdxW-1:0] RegMaxHoriz = 2'd0;
    localparam logic [CfgIdxW-1:0] RegMaxVert  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMaxYaw   = 2'd2;
    localparam logic [CfgIdxW-1:0] RegTimeout  = 2'd3;

    localparam logic [LimW-1:0] MaxHorizReset = 15'd5000;
    localparam logic [LimW-1:0] MaxVertReset  = 15'd2000;
    localparam logic [LimW-1:0] MaxYawReset   = 15'd1500;
    localparam logic [TmoW-1:0] TimeoutReset  = 26'd500000;
    localparam logic [TmoW-1:0] MinTimeout    = 26'd1000;

    typedef struct packed {
        logic [TimeW-1:0]       now_time;
        logic                   cmd_present;
        logic [TimeW-1:0]       cmd_stamp;
        logic signed [VelW-1:0] cmd_east;
        logic signed [VelW-1:0] cmd_north;
        logic signed [VelW-1:0] cmd_up;
        logic signed [VelW-1:0] cmd_yaw_rate;
        logic                   enable;
        logic                   liftoff_hold;
    } t_cmd_item;

    typedef struct packed {
        logic [TimeW-1:0]       out_time;
        logic signed [VelW-1:0] vel_north;
        logic signed [VelW-1:0] vel_east;
        logic signed [VelW-1:0] vel_down;
        logic signed [VelW-1:0] yaw_rate_out;
        logic                   commanding;
    } t_sp_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AGE,
        ST_SQN,
        ST_SQE,
        ST_SQL,
        ST_CHK,
        ST_SQA,
        ST_TGT,
        ST_TGTW,
        ST_TSQ,
        ST_TMUL,
        ST_TCMP,
        ST_OUT
    } t_state;

endpackage

// File: rtl/vclw_if.sv
interface vclw_cmd_if;
    logic                 valid;
    logic                 ready;
    vclw_pkg::t_cmd_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vclw_sp_if;
    logic                 valid;
    logic                 ready;
    vclw_pkg::t_sp_item   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vclw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vclw_pkg::CfgIdxW-1:0]    index;
    logic [vclw_pkg::CfgW-1:0]       value;
    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

// File: rtl/velocity_command_limiter_watchdog_unit.sv
// Channel  | Dir | Handshake        | Beat
// i_cmd    | in  | valid/ready      | one control tick (time, optional command, gates)
// o_sp     | out | valid/ready      | one NED setpoint
// i_cfg    | in  | valid/ready      | register index + write data, always ready
//
// Accept to next accept: under liftoff hold AGE returns to IDLE (no setpoint); a zero
// setpoint runs AGE-OUT; a passed-through horizontal vector AGE-SQN-SQE-SQL-CHK-OUT;
// a scaled one adds per component SQA-TGT-TGTW and a 15-bit restoring root search
// (TSQ-TMUL-TCMP per quotient bit) on one shared 32x32 multiplier. i_cmd is not
// ready until the setpoint is in the output register. Reset is synchronous and
// restores the register defaults and clears the stored command. A stalled o_sp only
// holds the final load; a new tick is still taken while the last setpoint waits.
module velocity_command_limiter_watchdog_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vclw_cmd_if.sink          i_cmd,
    vclw_sp_if.source         o_sp,
    vclw_cfg_if.sink          i_cfg
);

    // configuration
    logic [vclw_pkg::LimW-1:0] r_max_h;
    logic [vclw_pkg::LimW-1:0] r_max_v;
    logic [vclw_pkg::LimW-1:0] r_max_yaw;
    logic [vclw_pkg::TmoW-1:0] r_timeout;

    // stored command
    logic signed [vclw_pkg::VelW-1:0] r_east;
    logic signed [vclw_pkg::VelW-1:0] r_north;
    logic signed [vclw_pkg::VelW-1:0] r_up;
    logic signed [vclw_pkg::VelW-1:0] r_yaw;
    logic [vclw_pkg::TimeW-1:0]       r_stamp;
    logic                             r_have;

    // per tick
    logic [vclw_pkg::TimeW-1:0]       r_now;
    logic                             r_en;
    logic                             r_ovr;
    logic                             r_go;
    logic [vclw_pkg::MulW-1:0]        r_s;
    logic [2*vclw_pkg::LimW-1:0]      r_lsq;
    logic [vclw_pkg::CmpW-1:0]        r_tgt;
    logic [vclw_pkg::QBits-1:0]       r_q;
    logic [vclw_pkg::BitIdxW-1:0]     r_bit;
    logic                             r_comp;
    logic signed [vclw_pkg::VelW-1:0] r_vn;
    logic signed [vclw_pkg::VelW-1:0] r_ve;
    logic [vclw_pkg::ProdW-1:0]       r_prod;

    logic                             r_out_valid;
    vclw_pkg::t_sp_item               r_out;

    vclw_pkg::t_state r_state;
    vclw_pkg::t_state n_state;

    logic [vclw_pkg::MulW-1:0] w_mul_a;
    logic [vclw_pkg::MulW-1:0] w_mul_b;
    logic                      w_accept;
    logic                      w_can_load;
    logic                      w_fresh;
    logic                      w_scale;
    logic [vclw_pkg::TmoW-1:0] w_tmo;
    logic [vclw_pkg::TimeW:0]  w_age;
    logic [vclw_pkg::QBits-1:0] w_trial;
    logic                      w_fits;
    logic [vclw_pkg::QBits-1:0] w_qfin;
    logic signed [vclw_pkg::VelW-1:0] w_cur;
    logic signed [vclw_pkg::VelW-1:0] w_scaled;
    logic signed [vclw_pkg::VelW-1:0] w_down;
    logic signed [vclw_pkg::VelW-1:0] w_yaw;

    function automatic logic [vclw_pkg::VelW-1:0] abs16(input logic signed [vclw_pkg::VelW-1:0] v);
        logic signed [vclw_pkg::VelW:0] x;
        x = {v[vclw_pkg::VelW-1], v};
        if (v < 0) begin
            x = -x;
        end
        return x[vclw_pkg::VelW-1:0];
    endfunction

    function automatic logic signed [vclw_pkg::VelW-1:0] clamp_sym(
        input logic signed [vclw_pkg::VelW:0] v,
        input logic [vclw_pkg::LimW-1:0]      lim
    );
        logic signed [vclw_pkg::VelW:0] l;
        logic signed [vclw_pkg::VelW:0] r;
        l = $signed({2'b00, lim});
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r[vclw_pkg::VelW-1:0];
    endfunction

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_can_load = !r_out_valid || o_sp.ready;

    assign w_tmo   = (r_timeout < vclw_pkg::MinTimeout) ? vclw_pkg::MinTimeout : r_timeout;
    assign w_age   = {1'b0, r_now} - {1'b0, r_stamp};
    // borrow set: command from the future, always fresh
    assign w_fresh = r_have &&
                     !(!w_age[vclw_pkg::TimeW] &&
                       (w_age[vclw_pkg::TimeW-1:0] > {{(vclw_pkg::TimeW-vclw_pkg::TmoW){1'b0}}, w_tmo}));
    // r_prod holds L^2 in ST_CHK
    assign w_scale = r_go && (r_s > r_prod[vclw_pkg::MulW-1:0]) && (r_s > 32'd1);

    assign w_trial = r_q | (15'd1 << r_bit);
    assign w_fits  = r_prod[vclw_pkg::CmpW-1:0] <= r_tgt;
    assign w_qfin  = w_fits ? w_trial : r_q;
    assign w_cur   = r_comp ? r_east : r_north;
    assign w_scaled = (w_cur < 0) ? -$signed({1'b0, w_qfin}) : $signed({1'b0, w_qfin});

    assign w_down = clamp_sym(-$signed({r_up[vclw_pkg::VelW-1], r_up}), r_max_v);
    assign w_yaw  = clamp_sym($signed({r_yaw[vclw_pkg::VelW-1], r_yaw}), r_max_yaw);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vclw_pkg::ST_IDLE: if (w_accept) n_state = vclw_pkg::ST_AGE;
            vclw_pkg::ST_AGE: begin
                if (r_ovr) begin
                    n_state = vclw_pkg::ST_IDLE;
                end else if (r_en && w_fresh) begin
                    n_state = vclw_pkg::ST_SQN;
                end else begin
                    n_state = vclw_pkg::ST_OUT;
                end
            end
            vclw_pkg::ST_SQN:  n_state = vclw_pkg::ST_SQE;
            vclw_pkg::ST_SQE:  n_state = vclw_pkg::ST_SQL;
            vclw_pkg::ST_SQL:  n_state = vclw_pkg::ST_CHK;
            vclw_pkg::ST_CHK:  n_state = w_scale ? vclw_pkg::ST_SQA : vclw_pkg::ST_OUT;
            vclw_pkg::ST_SQA:  n_state = vclw_pkg::ST_TGT;
            vclw_pkg::ST_TGT:  n_state = vclw_pkg::ST_TGTW;
            vclw_pkg::ST_TGTW: n_state = vclw_pkg::ST_TSQ;
            vclw_pkg::ST_TSQ:  n_state = vclw_pkg::ST_TMUL;
            vclw_pkg::ST_TMUL: n_state = vclw_pkg::ST_TCMP;
            vclw_pkg::ST_TCMP: begin
                if (r_bit != '0) begin
                    n_state = vclw_pkg::ST_TSQ;
                end else if (r_comp) begin
                    n_state = vclw_pkg::ST_OUT;
                end else begin
                    n_state = vclw_pkg::ST_SQA;
                end
            end
            vclw_pkg::ST_OUT:  if (w_can_load) n_state = vclw_pkg::ST_IDLE;
            default:           n_state = vclw_pkg::ST_IDLE;
        endcase
    end

    // outputs: handshake and multiplier operands
    always_comb begin
        i_cmd.ready = (r_state == vclw_pkg::ST_IDLE);
        i_cfg.ready = 1'b1;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            vclw_pkg::ST_SQN: begin
                w_mul_a = {16'd0, abs16(r_north)};
                w_mul_b = {16'd0, abs16(r_north)};
            end
            vclw_pkg::ST_SQE: begin
                w_mul_a = {16'd0, abs16(r_east)};
                w_mul_b = {16'd0, abs16(r_east)};
            end
            vclw_pkg::ST_SQL: begin
                w_mul_a = {17'd0, r_max_h};
                w_mul_b = {17'd0, r_max_h};
            end
            vclw_pkg::ST_SQA: begin
                w_mul_a = {16'd0, abs16(w_cur)};
                w_mul_b = {16'd0, abs16(w_cur)};
            end
            vclw_pkg::ST_TGT: begin
                // a^2 * L^2
                w_mul_a = r_prod[vclw_pkg::MulW-1:0];
                w_mul_b = {2'd0, r_lsq};
            end
            vclw_pkg::ST_TSQ: begin
                w_mul_a = {17'd0, w_trial};
                w_mul_b = {17'd0, w_trial};
            end
            vclw_pkg::ST_TMUL: begin
                // t^2 * s
                w_mul_a = r_prod[vclw_pkg::MulW-1:0];
                w_mul_b = r_s;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vclw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_max_h     <= vclw_pkg::MaxHorizReset;
            r_max_v     <= vclw_pkg::MaxVertReset;
            r_max_yaw   <= vclw_pkg::MaxYawReset;
            r_timeout   <= vclw_pkg::TimeoutReset;
            r_east      <= '0;
            r_north     <= '0;
            r_up        <= '0;
            r_yaw       <= '0;
            r_stamp     <= '0;
            r_have      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    vclw_pkg::RegMaxHoriz: r_max_h   <= i_cfg.value[vclw_pkg::LimW-1:0];
                    vclw_pkg::RegMaxVert:  r_max_v   <= i_cfg.value[vclw_pkg::LimW-1:0];
                    vclw_pkg::RegMaxYaw:   r_max_yaw <= i_cfg.value[vclw_pkg::LimW-1:0];
                    vclw_pkg::RegTimeout:  r_timeout <= i_cfg.value[vclw_pkg::TmoW-1:0];
                    default: ;
                endcase
            end

            if (w_accept && i_cmd.data.cmd_present && (i_cmd.data.cmd_stamp != '0)) begin
                r_east  <= i_cmd.data.cmd_east;
                r_north <= i_cmd.data.cmd_north;
                r_up    <= i_cmd.data.cmd_up;
                r_yaw   <= i_cmd.data.cmd_yaw_rate;
                r_stamp <= i_cmd.data.cmd_stamp;
                r_have  <= 1'b1;
            end

            if (r_state == vclw_pkg::ST_OUT && w_can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_sp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= i_cmd.data.now_time;
            r_en  <= i_cmd.data.enable;
            r_ovr <= i_cmd.data.liftoff_hold;
        end
        unique case (r_state)
            vclw_pkg::ST_AGE: r_go <= r_en && w_fresh;
            vclw_pkg::ST_SQE: r_s  <= r_prod[vclw_pkg::MulW-1:0];
            vclw_pkg::ST_SQL: r_s  <= r_s + r_prod[vclw_pkg::MulW-1:0];
            vclw_pkg::ST_CHK: begin
                r_lsq  <= r_prod[2*vclw_pkg::LimW-1:0];
                r_vn   <= r_north;
                r_ve   <= r_east;
                r_comp <= 1'b0;
            end
            vclw_pkg::ST_TGTW: begin
                r_tgt <= r_prod[vclw_pkg::CmpW-1:0];
                r_q   <= '0;
                r_bit <= 4'(vclw_pkg::QBits - 1);
            end
            vclw_pkg::ST_TCMP: begin
                r_q <= w_qfin;
                if (r_bit == '0) begin
                    if (r_comp) begin
                        r_ve <= w_scaled;
                    end else begin
                        r_vn <= w_scaled;
                    end
                    r_comp <= 1'b1;
                end else begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            vclw_pkg::ST_OUT: begin
                if (w_can_load) begin
                    r_out.out_time <= r_now;
                    if (r_go) begin
                        r_out.vel_north    <= r_vn;
                        r_out.vel_east     <= r_ve;
                        r_out.vel_down     <= w_down;
                        r_out.yaw_rate_out <= w_yaw;
                        r_out.commanding   <= 1'b1;
                    end else begin
                        r_out.vel_north    <= '0;
                        r_out.vel_east     <= '0;
                        r_out.vel_down     <= '0;
                        r_out.yaw_rate_out <= '0;
                        r_out.commanding   <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_sp.valid = r_out_valid;
    assign o_sp.data  = r_out;

    a_accept_to_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == vclw_pkg::ST_AGE)
        else $error("accepted tick did not start the age check");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == vclw_pkg::ST_OUT))
        else $error("setpoint loaded outside the output step");

    a_zero_setpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sp.valid && !o_sp.data.commanding) |->
            (o_sp.data.vel_north == '0 && o_sp.data.vel_east == '0 &&
             o_sp.data.vel_down == '0 && o_sp.data.yaw_rate_out == '0))
        else $error("zero setpoint carries nonzero velocity");

    a_root_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vclw_pkg::ST_TCMP && r_bit == '0) |=>
            (r_state == vclw_pkg::ST_OUT || r_state == vclw_pkg::ST_SQA))
        else $error("root search did not finish after last bit");

endmodule
